// ===== hw/rtl/fra_pkg.sv =====
// ----------------------------------------------------------------------------
// fra_pkg - shared definitions for the four-register ALU executor
// Widths, operation codes and stream payload layouts.
// ----------------------------------------------------------------------------
package fra_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int PC_WIDTH   = 16;
	localparam int IMM_WIDTH  = 32;
	localparam int NUM_REGS   = 4;
	localparam int REG_IDX_W  = $clog2(NUM_REGS);
	localparam int OP_W       = 3;

	// iteration counter for the shift-add multiply and the restoring divide
	localparam int CNT_W = $clog2(DATA_WIDTH);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

	localparam int IN_FIELDS_W  = OP_W + 2 * REG_IDX_W + IMM_WIDTH;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = DATA_WIDTH + PC_WIDTH;

	typedef enum logic [OP_W-1:0] {
		OP_MOV = 3'd0,
		OP_ADD = 3'd1,
		OP_SUB = 3'd2,
		OP_MUL = 3'd3,
		OP_DIV = 3'd4,
		OP_INC = 3'd5,
		OP_DEC = 3'd6,
		OP_END = 3'd7
	} op_t;

	// input tdata layout, lowest field last
	typedef struct packed {
		logic [IN_TDATA_W-IN_FIELDS_W-1:0] pad;
		logic [IMM_WIDTH-1:0]              immediate;
		logic [REG_IDX_W-1:0]              src_reg;
		logic [REG_IDX_W-1:0]              dest_reg;
		op_t                               func;
	} in_data_t;

endpackage

// ===== hw/rtl/four_register_alu_executor.sv =====
// ----------------------------------------------------------------------------
// four_register_alu_executor - decoded instruction executor on four registers
// Executes MOV, ADD, SUB, MUL, DIV, INC, DEC and END on four 32-bit signed
// registers with a 16-bit program counter, one result transaction per
// instruction. All data arithmetic runs through one shared 33-bit adder under a
// small sequencer, and the input is not ready while an instruction executes.
// MUL runs 32 shift-add steps on the adder. DIV with a nonzero divisor
// runs two sign-magnitude conversions, 32 restoring steps and one floor
// correction, all on the adder. MOV, ADD, SUB, INC, DEC, END and DIV by
// zero go straight from the operation state to the result. A result still
// waiting at the output delays the next input transaction. Registers and
// PC read as zero after reset.
// ----------------------------------------------------------------------------
module four_register_alu_executor
	import fra_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // func, dest_reg, src_reg, immediate, zero pad
	input  logic                   s_axis_tuser,  // src_is_reg
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // dest_value, pc_value
	output logic                   m_axis_tuser   // status
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_OPER = 8'b0000_0010,
		S_ABSN = 8'b0000_0100,
		S_ABSD = 8'b0000_1000,
		S_MUL  = 8'b0001_0000,
		S_DIV  = 8'b0010_0000,
		S_FIX  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [PC_WIDTH-1:0]  pc_q;
	logic [PC_WIDTH-1:0]  pc_next;
	logic [NUM_REGS-1:0]  gpr_vld_q;

	logic [DATA_WIDTH-1:0] gpr_mem [NUM_REGS];
	logic [DATA_WIDTH-1:0] rd_dst_q;
	logic [DATA_WIDTH-1:0] rd_src_q;
	logic                  rd_dst_vld_q;
	logic                  rd_src_vld_q;

	op_t                   op_q;
	logic [REG_IDX_W-1:0]  dest_q;
	logic                  src_is_reg_q;
	logic [DATA_WIDTH-1:0] imm_q;

	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] opa_q;
	logic [DATA_WIDTH-1:0] opb_q;
	logic                  neg_q;
	logic                  status_q;

	in_data_t              in_d;
	logic                  in_acc;
	logic                  out_free;
	logic                  wb_en;
	logic [DATA_WIDTH-1:0] dst_op;
	logic [DATA_WIDTH-1:0] src_op;
	logic                  div_zero;
	logic [DATA_WIDTH-1:0] partial;

	logic [DATA_WIDTH-1:0] add_a;
	logic [DATA_WIDTH-1:0] add_b;
	logic                  add_inv;
	logic                  add_cin;
	logic [DATA_WIDTH:0]   add_sum;

	assign in_d          = in_data_t'(s_axis_tdata);
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign out_free      = ~m_axis_tvalid | m_axis_tready;
	assign wb_en         = (state_q == S_DONE) & out_free;
	assign pc_next       = pc_q + PC_WIDTH'(1);

	// registers never written since reset read as zero
	assign dst_op   = rd_dst_vld_q ? rd_dst_q : '0;
	assign src_op   = src_is_reg_q ? (rd_src_vld_q ? rd_src_q : '0) : imm_q;
	assign div_zero = (src_op == '0);
	assign partial  = {acc_q[DATA_WIDTH-2:0], opb_q[DATA_WIDTH-1]};

	// shared adder; carry out is the no-borrow flag when subtracting
	assign add_sum = {1'b0, add_a} + {1'b0, (add_inv ? ~add_b : add_b)}
		+ {{DATA_WIDTH{1'b0}}, add_cin};

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_inv = 1'b0;
		add_cin = 1'b0;
		unique case (state_q)
			S_OPER: begin
				unique case (op_q)
					OP_MOV: add_b = src_op;
					OP_ADD: begin
						add_a = dst_op;
						add_b = src_op;
					end
					OP_SUB: begin
						add_a   = dst_op;
						add_b   = src_op;
						add_inv = 1'b1;
						add_cin = 1'b1;
					end
					OP_INC: begin
						add_a = dst_op;
						add_b = DATA_WIDTH'(1);
					end
					OP_DEC: begin
						add_a   = dst_op;
						add_b   = DATA_WIDTH'(1);
						add_inv = 1'b1;
						add_cin = 1'b1;
					end
					OP_DIV, OP_END: add_a = dst_op;
					OP_MUL: ;  // clear the accumulator
					default: ;
				endcase
			end
			S_ABSN: begin
				add_b   = opb_q;
				add_inv = 1'b1;
				add_cin = 1'b1;
			end
			S_ABSD: begin
				add_b   = opa_q;
				add_inv = 1'b1;
				add_cin = 1'b1;
			end
			S_MUL: begin
				add_a = acc_q;
				add_b = opb_q[0] ? opa_q : '0;
			end
			S_DIV: begin
				add_a   = partial;
				add_b   = opa_q;
				add_inv = 1'b1;
				add_cin = 1'b1;
			end
			S_FIX: begin
				// negative quotient: 0 - q - (remainder != 0)
				add_b   = opb_q;
				add_inv = neg_q;
				add_cin = neg_q & ~(|acc_q);
			end
			default: ;
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			pc_q          <= '0;
			gpr_vld_q     <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (wb_en)
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready)
				m_axis_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid)
						state_q <= S_OPER;
				end
				S_OPER: begin
					cnt_q <= '0;
					priority if (op_q == OP_MUL)
						state_q <= S_MUL;
					else if (op_q == OP_DIV && !div_zero)
						state_q <= S_ABSN;
					else
						state_q <= S_DONE;
				end
				S_ABSN: state_q <= S_ABSD;
				S_ABSD: state_q <= S_DIV;
				S_MUL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == LAST_STEP)
						state_q <= S_DONE;
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == LAST_STEP)
						state_q <= S_FIX;
				end
				S_FIX: state_q <= S_DONE;
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						state_q           <= S_IDLE;
						pc_q              <= pc_next;
						gpr_vld_q[dest_q] <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// register file: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wb_en)
			gpr_mem[dest_q] <= acc_q;
		if (in_acc) begin
			rd_dst_q <= gpr_mem[in_d.dest_reg];
			rd_src_q <= gpr_mem[in_d.src_reg];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q         <= in_d.func;
			dest_q       <= in_d.dest_reg;
			src_is_reg_q <= s_axis_tuser;
			imm_q        <= in_d.immediate;
			rd_dst_vld_q <= gpr_vld_q[in_d.dest_reg];
			rd_src_vld_q <= gpr_vld_q[in_d.src_reg];
		end
		unique case (state_q)
			S_OPER: begin
				acc_q    <= add_sum[DATA_WIDTH-1:0];
				status_q <= (op_q == OP_DIV) && div_zero;
				neg_q    <= dst_op[DATA_WIDTH-1] ^ src_op[DATA_WIDTH-1];
				if (op_q == OP_MUL) begin
					opa_q <= dst_op;
					opb_q <= src_op;
				end else begin
					opa_q <= src_op;
					opb_q <= dst_op;
				end
			end
			S_ABSN: begin
				if (opb_q[DATA_WIDTH-1])
					opb_q <= add_sum[DATA_WIDTH-1:0];
			end
			S_ABSD: begin
				if (opa_q[DATA_WIDTH-1])
					opa_q <= add_sum[DATA_WIDTH-1:0];
				acc_q <= '0;
			end
			S_MUL: begin
				acc_q <= add_sum[DATA_WIDTH-1:0];
				opa_q <= {opa_q[DATA_WIDTH-2:0], 1'b0};
				opb_q <= {1'b0, opb_q[DATA_WIDTH-1:1]};
			end
			S_DIV: begin
				// keep the difference only when the trial subtract did not borrow
				acc_q <= add_sum[DATA_WIDTH] ? add_sum[DATA_WIDTH-1:0] : partial;
				opb_q <= {opb_q[DATA_WIDTH-2:0], add_sum[DATA_WIDTH]};
			end
			S_FIX: acc_q <= add_sum[DATA_WIDTH-1:0];
			S_DONE: begin
				if (out_free) begin
					m_axis_tdata <= {pc_next, acc_q};
					m_axis_tuser <= status_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/fra_checker.sv =====
// ----------------------------------------------------------------------------
// fra_checker - port-level checks for the four-register ALU executor
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module fra_checker
	import fra_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser
);

	// a stalled result transaction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result payload changed while stalled");

	// an accepted instruction keeps the input not ready past its S_OPER state
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> ##2 !s_axis_tready)
		else $error("input ready too soon after an instruction");

	// a new result appears only as the executor returns to idle
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("result issued while the executor is busy");

endmodule

bind four_register_alu_executor fra_checker u_fra_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
